[hw/rtl/ipv4hg_pkg.sv]
// Shared types and constants for the IPv4 header generator.
package ipv4hg_pkg;

	localparam int unsigned HdrBytes  = 20;
	localparam int unsigned IdxW      = 5;
	localparam int unsigned HdrBits   = HdrBytes * 8;

	localparam logic [IdxW-1:0] LastIndex  = IdxW'(HdrBytes - 1);
	localparam logic [15:0]     MaxPayload = 16'd65515;
	localparam logic [15:0]     HdrLen     = 16'(HdrBytes);

	localparam logic [7:0]  VerIhl    = 8'h45;
	localparam logic [7:0]  FlagsDf   = 8'h40;
	localparam logic [7:0]  DefTtl    = 8'd64;
	// Constant words of the header summed up front: 0x4500 + 0x4000 + (64 << 8)
	localparam logic [15:0] ConstWordSum = 16'hC500;

	typedef struct packed {
		logic            valid;
		logic [7:0]      data;
		logic [IdxW-1:0] index;
		logic            last;
	} cell_t;

	typedef struct packed {
		logic [7:0]  protocol;
		logic [15:0] total_len;
		logic [31:0] src;
		logic [31:0] dst;
		logic [18:0] acc;
	} hdr_fields_t;

endpackage

[hw/rtl/ipv4hg_req_if.sv]
// Request channel: protocol, payload length and addresses.
interface ipv4hg_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  protocol_number;
	logic [15:0] payload_length;
	logic [31:0] source_address;
	logic [31:0] dest_address;

	modport source (output valid, protocol_number, payload_length, source_address,
		dest_address, input ready);
	modport sink (input valid, protocol_number, payload_length, source_address,
		dest_address, output ready);
endinterface

[hw/rtl/ipv4hg_hdr_if.sv]
// Header byte channel: one header byte per item.
interface ipv4hg_hdr_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic [4:0] byte_index;
	logic       last_byte;

	modport source (output valid, header_byte, byte_index, last_byte, input ready);
	modport sink (input valid, header_byte, byte_index, last_byte, output ready);
endinterface

[hw/rtl/ipv4_header_generator_core.sv]
// IPv4 header generator: request in, twenty header bytes out.
//
// Usage:
//   req  - one item per header: protocol, payload length, source and
//          destination address. Payload lengths above 65515 are clamped.
//   hdr  - one item per header byte in wire order, with its index 0..19
//          and last_byte set on byte 19.
// Path: a request is registered in clamp/partial sums, then in checksum
//   accumulation, then folded and loaded in parallel into the byte chain,
//   whose head cell offers the first byte of its header.
// Pacing: requests are paced by the byte-wide output chain of twenty cells,
//   which shifts one byte a cycle while hdr.ready stays high.
//   The next request is accepted and summed while the current header drains
//   and is loaded in the cycle its last byte leaves, so headers follow
//   each other with no gap.
// Stall: with hdr.ready low the chain holds; the two front stages fill and
//   then req.ready drops. Nothing is lost or repeated.
// Reset: arst_n clears all valid flags; the block comes up empty and ready.
module ipv4_header_generator_core (
	input  logic           clk,
	input  logic           arst_n,
	ipv4hg_req_if.sink     req,
	ipv4hg_hdr_if.source   hdr
);

	localparam int unsigned N = ipv4hg_pkg::HdrBytes;

	logic                    fields_valid;
	logic                    chain_free;
	logic                    load;
	logic                    shift;
	ipv4hg_pkg::hdr_fields_t fields;
	logic [16:0]             fold1;
	logic [15:0]             fold2;
	logic [15:0]             csum;
	logic [ipv4hg_pkg::HdrBits-1:0] hdr_vec;
	ipv4hg_pkg::cell_t       chain[N];

	// front end: clamp, partial sums, accumulate
	ipv4hg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.fields_valid (fields_valid),
		.fields_ready (chain_free),
		.fields       (fields)
	);

	// fold the end-around carries twice, then invert
	assign fold1 = {1'b0, fields.acc[15:0]} + {14'd0, fields.acc[18:16]};
	assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
	assign csum  = ~fold2;

	// header in wire order, byte 0 in the top bits
	assign hdr_vec = {ipv4hg_pkg::VerIhl, 8'h00, fields.total_len, 16'h0000,
		ipv4hg_pkg::FlagsDf, 8'h00, ipv4hg_pkg::DefTtl, fields.protocol, csum,
		fields.src, fields.dst};

	// the chain takes a new header once empty or as its final byte leaves
	assign chain_free = !chain[0].valid || (hdr.ready && chain[0].last);
	assign load       = fields_valid && chain_free;
	assign shift      = hdr.ready && chain[0].valid;

	for (genvar i = 0; i < N; i++) begin : g_cell
		ipv4hg_pkg::cell_t load_d;
		ipv4hg_pkg::cell_t next_d;

		assign load_d = '{valid: 1'b1,
			data: hdr_vec[ipv4hg_pkg::HdrBits-1-8*i -: 8],
			index: ipv4hg_pkg::IdxW'(i),
			last: (i == N-1)};

		if (i == N-1) begin : g_tail
			assign next_d = '0;
		end else begin : g_mid
			assign next_d = chain[i+1];
		end

		ipv4hg_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load),
			.shift     (shift),
			.load_data (load_d),
			.next_data (next_d),
			.slot      (chain[i])
		);
	end

	// present the head cell
	assign hdr.valid       = chain[0].valid;
	assign hdr.header_byte = chain[0].data;
	assign hdr.byte_index  = chain[0].index;
	assign hdr.last_byte   = chain[0].last;

`ifndef SYNTH
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.last_byte |-> hdr.byte_index == ipv4hg_pkg::LastIndex)
		else $error("last flag away from final byte");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.ready && !hdr.last_byte |=> hdr.valid)
		else $error("gap inside a header");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.ready && !hdr.last_byte |=>
			hdr.byte_index == 5'($past(hdr.byte_index) + 5'd1))
		else $error("byte index did not advance by one");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.ready && hdr.last_byte |=>
			!hdr.valid || hdr.byte_index == 5'd0)
		else $error("header did not start at byte zero");
`endif

endmodule

[hw/rtl/ipv4hg_front.sv]
// Request front end: length clamp and two-stage checksum accumulation.
module ipv4hg_front (
	input  logic                       clk,
	input  logic                       arst_n,
	ipv4hg_req_if.sink                 req,
	output logic                       fields_valid,
	input  logic                       fields_ready,
	output ipv4hg_pkg::hdr_fields_t    fields
);

	logic        v1_q;
	logic        v2_q;
	logic        take2;
	logic        adv1;
	logic        acc_in;

	logic [7:0]  proto_s1;
	logic [15:0] len_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic [16:0] psrc_s1;
	logic [16:0] pdst_s1;
	logic [15:0] clamped;

	ipv4hg_pkg::hdr_fields_t fields_s2;

	assign take2     = !v2_q || fields_ready;
	assign adv1      = v1_q && take2;
	assign req.ready = !v1_q || take2;
	assign acc_in    = req.valid && req.ready;

	// clamp so the total length fits in sixteen bits
	assign clamped = (req.payload_length > ipv4hg_pkg::MaxPayload) ?
		ipv4hg_pkg::MaxPayload : req.payload_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (acc_in) begin
				v1_q <= 1'b1;
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1) begin
				v2_q <= 1'b1;
			end else if (fields_ready) begin
				v2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			proto_s1 <= req.protocol_number;
			len_s1   <= clamped + ipv4hg_pkg::HdrLen;
			src_s1   <= req.source_address;
			dst_s1   <= req.dest_address;
			psrc_s1  <= {1'b0, req.source_address[31:16]} + {1'b0, req.source_address[15:0]};
			pdst_s1  <= {1'b0, req.dest_address[31:16]} + {1'b0, req.dest_address[15:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			fields_s2.protocol  <= proto_s1;
			fields_s2.total_len <= len_s1;
			fields_s2.src       <= src_s1;
			fields_s2.dst       <= dst_s1;
			fields_s2.acc       <= {3'b000, ipv4hg_pkg::ConstWordSum}
				+ {3'b000, len_s1} + {11'd0, proto_s1}
				+ {2'b00, psrc_s1} + {2'b00, pdst_s1};
		end
	end

	assign fields_valid = v2_q;
	assign fields       = fields_s2;

endmodule

[hw/rtl/ipv4hg_cell.sv]
// One byte cell of the header shift chain.
module ipv4hg_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               shift,
	input  ipv4hg_pkg::cell_t  load_data,
	input  ipv4hg_pkg::cell_t  next_data,
	output ipv4hg_pkg::cell_t  slot
);

	logic       valid_q;
	logic [7:0] data_q;
	logic [4:0] index_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_data.valid;
		end else if (shift) begin
			valid_q <= next_data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q  <= load_data.data;
			index_q <= load_data.index;
			last_q  <= load_data.last;
		end else if (shift) begin
			data_q  <= next_data.data;
			index_q <= next_data.index;
			last_q  <= next_data.last;
		end
	end

	assign slot = '{valid: valid_q, data: data_q, index: index_q, last: last_q};

endmodule
